// ----- sv/msp_pkg.sv -----
// shared types, codes and the crc byte update for the supply poll framer
package msp_pkg;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned FRAME_LEN = 8;
    localparam int unsigned BYTE_IDX_W = $clog2(FRAME_LEN);

    localparam logic [PADDR_W-3:0] REG_IDX_SLAVE_ADDRESS = 1'b0;

    localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h01;

    localparam logic [7:0] FC_READ = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;

    localparam logic [15:0] REG_POWER_ON = 16'h0001;
    localparam logic [15:0] REG_VOLTAGE = 16'h0030;
    localparam logic [15:0] REG_READBACK = 16'h0010;
    localparam logic [15:0] READ_COUNT = 16'h0002;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [1:0] KIND_POWER = 2'd0;
    localparam logic [1:0] KIND_VOLT = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [BYTE_IDX_W-1:0] IDX_SLAVE = 3'd0;
    localparam logic [BYTE_IDX_W-1:0] IDX_FUNC = 3'd1;
    localparam logic [BYTE_IDX_W-1:0] IDX_REG_HI = 3'd2;
    localparam logic [BYTE_IDX_W-1:0] IDX_REG_LO = 3'd3;
    localparam logic [BYTE_IDX_W-1:0] IDX_VAL_HI = 3'd4;
    localparam logic [BYTE_IDX_W-1:0] IDX_VAL_LO = 3'd5;
    localparam logic [BYTE_IDX_W-1:0] IDX_CRC_LO = 3'd6;
    localparam logic [BYTE_IDX_W-1:0] IDX_CRC_HI = 3'd7;

    typedef enum logic [2:0] {
        PH_POWER = 3'b001,
        PH_VOLT  = 3'b010,
        PH_READ  = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0]  func;
        logic [15:0] reg_addr;
        logic [15:0] value;
        logic [1:0]  kind;
    } t_frame_hdr;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- sv/msp_ifs.sv -----
// request and frame byte channel interfaces
interface msp_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  power_on_request;
    logic [15:0] voltage_setpoint;

    modport source (output valid, output power_on_request, output voltage_setpoint,
                    input ready);
    modport sink (input valid, input power_on_request, input voltage_setpoint,
                  output ready);
endinterface

interface msp_frm_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [1:0] frame_kind;
    logic       last_byte;

    modport source (output valid, output frame_byte, output frame_kind, output last_byte,
                    input ready);
    modport sink (input valid, input frame_byte, input frame_kind, input last_byte,
                  output ready);
endinterface

// ----- sv/msp_frame_select.sv -----
// phase sequencer that picks the frame for each request beat and registers its header
module msp_frame_select (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_power_on_request,
    input  logic [15:0]           i_voltage_setpoint,
    output logic                  o_valid,
    input  logic                  i_ready,
    output msp_pkg::t_frame_hdr   o_hdr
);
    import msp_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_sent_on, n_sent_on;
    logic [15:0] r_sent_volt, n_sent_volt;
    logic       r_valid, n_valid;
    t_frame_hdr r_hdr, n_hdr;
    logic       w_accept;
    logic       w_on_diff;
    logic       w_volt_diff;

    assign o_ready = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_on_diff = i_power_on_request != r_sent_on;
    assign w_volt_diff = i_voltage_setpoint != r_sent_volt;

    always_comb begin
        n_phase = r_phase;
        n_sent_on = r_sent_on;
        n_sent_volt = r_sent_volt;
        n_hdr = r_hdr;
        n_valid = r_valid && !i_ready;
        if (w_accept) begin
            n_valid = 1'b1;
            n_hdr = '{func: FC_READ, reg_addr: REG_READBACK, value: READ_COUNT,
                      kind: KIND_READ};
            case (r_phase)
                PH_POWER: begin
                    if (w_on_diff) begin
                        n_sent_on = i_power_on_request;
                        n_hdr = '{func: FC_WRITE_SINGLE, reg_addr: REG_POWER_ON,
                                  value: {8'h00, i_power_on_request}, kind: KIND_POWER};
                    end else if (w_volt_diff) begin
                        n_phase = PH_VOLT;
                        n_sent_volt = i_voltage_setpoint;
                        n_hdr = '{func: FC_WRITE_SINGLE, reg_addr: REG_VOLTAGE,
                                  value: i_voltage_setpoint, kind: KIND_VOLT};
                    end else begin
                        n_phase = PH_READ;
                    end
                end
                PH_VOLT: begin
                    if (w_volt_diff) begin
                        n_sent_volt = i_voltage_setpoint;
                        n_hdr = '{func: FC_WRITE_SINGLE, reg_addr: REG_VOLTAGE,
                                  value: i_voltage_setpoint, kind: KIND_VOLT};
                    end else begin
                        n_phase = PH_READ;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_POWER;
            r_sent_on <= '0;
            r_sent_volt <= '0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_sent_on <= n_sent_on;
            r_sent_volt <= n_sent_volt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

    assign o_valid = r_valid;
    assign o_hdr = r_hdr;

endmodule

// ----- sv/msp_frame_tx.sv -----
// byte serializer that sends one frame and folds each header byte into the crc
module msp_frame_tx (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_slave_address,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  msp_pkg::t_frame_hdr   i_hdr,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_frame_byte,
    output logic [1:0]            o_frame_kind,
    output logic                  o_last_byte
);
    import msp_pkg::*;

    logic                  r_valid, n_valid;
    logic [BYTE_IDX_W-1:0] r_idx, n_idx;
    logic [15:0]           r_crc, n_crc;
    t_frame_hdr            r_hdr, n_hdr;
    logic [7:0]            w_byte;
    logic                  w_out_accept;
    logic                  w_last;

    always_comb begin
        case (r_idx)
            IDX_SLAVE:  w_byte = i_slave_address;
            IDX_FUNC:   w_byte = r_hdr.func;
            IDX_REG_HI: w_byte = r_hdr.reg_addr[15:8];
            IDX_REG_LO: w_byte = r_hdr.reg_addr[7:0];
            IDX_VAL_HI: w_byte = r_hdr.value[15:8];
            IDX_VAL_LO: w_byte = r_hdr.value[7:0];
            IDX_CRC_LO: w_byte = r_crc[7:0];
            IDX_CRC_HI: w_byte = r_crc[15:8];
            default:    w_byte = r_crc[15:8];
        endcase
    end

    assign w_last = r_idx == IDX_CRC_HI;
    assign w_out_accept = r_valid && i_ready;
    assign o_ready = !r_valid || (w_out_accept && w_last);

    always_comb begin
        n_valid = r_valid;
        n_idx = r_idx;
        n_crc = r_crc;
        n_hdr = r_hdr;
        if (w_out_accept) begin
            n_idx = r_idx + 1'b1;
            if (r_idx <= IDX_VAL_LO) begin
                n_crc = crc16_byte(r_crc, w_byte);
            end
            if (w_last) begin
                n_valid = 1'b0;
            end
        end
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
            n_idx = IDX_SLAVE;
            n_crc = CRC_INIT;
            n_hdr = i_hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx <= IDX_SLAVE;
        end else begin
            r_valid <= n_valid;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        r_hdr <= n_hdr;
    end

    assign o_valid = r_valid;
    assign o_frame_byte = w_byte;
    assign o_frame_kind = r_hdr.kind;
    assign o_last_byte = w_last;

endmodule

// ----- sv/modbus_supply_poll_framer.sv -----
// top level of the modbus rtu poll framer for a programmable supply
//
// i_req takes one request beat: the wanted on/off state and voltage code.
// o_frm gives eight byte beats per request, in transmit order: slave
// address, function code, register address, value or count, crc low, crc
// high. frame_kind tells write on/off, write voltage or read; last_byte
// marks the crc high byte.
// a request beat is registered in the frame selector and then in the
// serializer; its first byte shows on o_frm in the cycle after the selector
// hands it on. the serializer sends one byte per cycle while o_frm is
// ready, and frames follow each other with no gap. one request waits in the
// selector while a frame goes out.
// a stall on o_frm holds the current byte; i_req backs up once the waiting
// request is full.
// reset empties both stages, returns the sequencer to the on/off phase,
// clears the remembered values and sets the slave address to 1.
// the slave address register sits at byte address 0 of the apb port.
module modbus_supply_poll_framer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    msp_req_if.sink                       i_req,
    msp_frm_if.source                     o_frm,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msp_pkg::PADDR_W-1:0]   paddr,
    input  logic [msp_pkg::PDATA_W-1:0]   pwdata,
    output logic [msp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import msp_pkg::*;

    logic [7:0] r_slave_address;
    logic       w_cfg_write;
    logic       w_sel_valid;
    logic       w_tx_ready;
    t_frame_hdr w_hdr;

    assign pready = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= SLAVE_ADDRESS_RESET;
        end else if (w_cfg_write && paddr[PADDR_W-1:2] == REG_IDX_SLAVE_ADDRESS) begin
            r_slave_address <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_IDX_SLAVE_ADDRESS) begin
            prdata = {{(PDATA_W-8){1'b0}}, r_slave_address};
        end
    end

    msp_frame_select u_select (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_req.valid),
        .o_ready            (i_req.ready),
        .i_power_on_request (i_req.power_on_request),
        .i_voltage_setpoint (i_req.voltage_setpoint),
        .o_valid            (w_sel_valid),
        .i_ready            (w_tx_ready),
        .o_hdr              (w_hdr)
    );

    msp_frame_tx u_tx (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_slave_address (r_slave_address),
        .i_valid         (w_sel_valid),
        .o_ready         (w_tx_ready),
        .i_hdr           (w_hdr),
        .o_valid         (o_frm.valid),
        .i_ready         (o_frm.ready),
        .o_frame_byte    (o_frm.frame_byte),
        .o_frame_kind    (o_frm.frame_kind),
        .o_last_byte     (o_frm.last_byte)
    );

endmodule
